// ===== rtl/name_value_line_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the name/value line tokenizer
// Shared helpers so that every checking module reports in the same way.
// ----------------------------------------------------------------------------
`ifndef NAME_VALUE_LINE_TOKENIZER_MACROS_SVH
`define NAME_VALUE_LINE_TOKENIZER_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define NVT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Implication checked at every clock edge outside of reset.
`define NVT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/nvt_pkg.sv =====
// ----------------------------------------------------------------------------
// nvt_pkg
// Types, codes and constants shared by the name/value line tokenizer.
// ----------------------------------------------------------------------------
package nvt_pkg;

  // Default buffer sizes for the top-level parameters.
  localparam int unsigned MaxNameDefault  = 256;
  localparam int unsigned MaxValueDefault = 2048;

  // Depth of the queue between the classifier and the output side.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // Register widths and indexes.
  localparam int unsigned NameLimitW  = 8;
  localparam int unsigned ValueLimitW = 11;
  localparam logic [7:0]  NameLimitRst  = 8'd255;
  localparam logic [10:0] ValueLimitRst = 11'd2047;
  localparam logic RegNameLimit  = 1'b0;
  localparam logic RegValueLimit = 1'b1;

  // Characters with a special meaning.
  localparam logic [7:0] CharHash   = 8'h23;
  localparam logic [7:0] CharNl     = 8'h0A;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharCr     = 8'h0D;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_NAME_CHAR  = 3'd0,
    KIND_VALUE_CHAR = 3'd1,
    KIND_ENTRY_END  = 3'd2,
    KIND_NO_VALUE   = 3'd3,
    KIND_ABRUPT_END = 3'd4,
    KIND_NAME_OVF   = 3'd5,
    KIND_VALUE_OVF  = 3'd6,
    KIND_CLEAN_END  = 3'd7
  } kind_e;

  // Line parser phases. Code 7 is unused and treated as the first column.
  typedef enum logic [2:0] {
    PH_FIRST     = 3'd0,
    PH_COMMENT   = 3'd1,
    PH_FINDNAME  = 3'd2,
    PH_NAME      = 3'd3,
    PH_FINDVALUE = 3'd4,
    PH_VALUE     = 3'd5,
    PH_CONTINUE  = 3'd6
  } phase_e;

  // One input request.
  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } in_t;

  // One output request.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_char;
    logic       last;
  } out_t;

  // One result as produced by the classifier.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } res_t;

  // Queue entry: the one or two results caused by one input character.
  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } entry_t;

  // White space: space, tab, newline, vertical tab, form feed, return.
  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

// ===== rtl/nvt_front.sv =====
// ----------------------------------------------------------------------------
// nvt_front
// Accepts characters, runs the line parser state and pushes the results that
// each character causes into the queue as one entry.
// ----------------------------------------------------------------------------
module nvt_front #(
  parameter int unsigned MAX_NAME  = nvt_pkg::MaxNameDefault,
  parameter int unsigned MAX_VALUE = nvt_pkg::MaxValueDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  nvt_pkg::in_t        in_i,
  input  logic [7:0]          name_limit_i,
  input  logic [10:0]         value_limit_i,
  output logic                push_o,
  output nvt_pkg::entry_t     entry_o,
  input  logic                full_i
);
  import nvt_pkg::*;

  localparam int unsigned NameCw  = $clog2(MAX_NAME);
  localparam int unsigned ValueCw = $clog2(MAX_VALUE);

  phase_e             phase_q, phase_d;
  logic [NameCw-1:0]  name_cnt_q, name_cnt_d;
  logic [ValueCw-1:0] value_cnt_q, value_cnt_d;
  logic               held_valid_q, held_valid_d;
  logic [7:0]         held_char_q, held_char_d;

  logic [NameCw-1:0]  name_lim, name_base;
  logic [ValueCw-1:0] value_lim;
  logic               first_col, name_ok, value_ok, accept;
  logic [1:0]         n_res;
  res_t               res0, res1, name_res, value_res;
  logic               value_emit;
  logic [7:0]         c;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_i.ch;

  // Limits in effect are clipped to what the counters can hold.
  always_comb begin
    if ({1'b0, name_limit_i} > 9'(MAX_NAME - 1)) begin
      name_lim = NameCw'(MAX_NAME - 1);
    end else begin
      name_lim = NameCw'(name_limit_i);
    end
    if ({1'b0, value_limit_i} > 12'(MAX_VALUE - 1)) begin
      value_lim = ValueCw'(MAX_VALUE - 1);
    end else begin
      value_lim = ValueCw'(value_limit_i);
    end
  end

  // The first column, and the unused phase code, start a fresh entry.
  always_comb begin
    case (phase_q)
      PH_COMMENT, PH_FINDNAME, PH_NAME, PH_FINDVALUE, PH_VALUE, PH_CONTINUE: begin
        first_col = 1'b0;
      end
      default: begin
        first_col = 1'b1;
      end
    endcase
  end

  // Outcome of taking a name or a value character.
  always_comb begin
    name_base = first_col ? '0 : name_cnt_q;
    name_ok   = name_base < name_lim;
    name_res  = name_ok ? res_t'{kind: KIND_NAME_CHAR, ch: c}
                        : res_t'{kind: KIND_NAME_OVF, ch: 8'h00};
    value_ok   = value_cnt_q < value_lim;
    value_emit = value_ok ? held_valid_q : 1'b1;
    value_res  = value_ok ? res_t'{kind: KIND_VALUE_CHAR, ch: held_char_q}
                          : res_t'{kind: KIND_VALUE_OVF, ch: 8'h00};
  end

  // Parser next state and results for the presented character.
  always_comb begin
    phase_d      = phase_q;
    name_cnt_d   = name_cnt_q;
    value_cnt_d  = value_cnt_q;
    held_valid_d = held_valid_q;
    held_char_d  = held_char_q;
    n_res        = 2'd0;
    res0         = '{kind: KIND_NAME_CHAR, ch: 8'h00};
    res1         = '{kind: KIND_NAME_CHAR, ch: 8'h00};

    if (in_i.at_end) begin
      n_res        = 2'd1;
      res0.kind    = first_col ? KIND_CLEAN_END : KIND_ABRUPT_END;
      phase_d      = PH_FIRST;
      name_cnt_d   = '0;
      value_cnt_d  = '0;
      held_valid_d = 1'b0;
      held_char_d  = 8'h00;
    end else begin
      case (phase_q)
        PH_COMMENT: begin
          if (c == CharNl) begin
            phase_d = PH_FIRST;
          end
        end
        PH_FINDNAME: begin
          if (c == CharNl) begin
            phase_d = PH_FIRST;
          end else if (!is_blank(c)) begin
            n_res   = 2'd1;
            res0    = name_res;
            phase_d = PH_NAME;
            if (name_ok) begin
              name_cnt_d = name_base + NameCw'(1);
            end
          end
        end
        PH_NAME: begin
          if (c == CharNl) begin
            n_res        = 2'd1;
            res0.kind    = KIND_NO_VALUE;
            phase_d      = PH_FIRST;
            name_cnt_d   = '0;
            value_cnt_d  = '0;
            held_valid_d = 1'b0;
            held_char_d  = 8'h00;
          end else if (is_blank(c)) begin
            phase_d = PH_FINDVALUE;
          end else begin
            n_res = 2'd1;
            res0  = name_res;
            if (name_ok) begin
              name_cnt_d = name_base + NameCw'(1);
            end
          end
        end
        PH_FINDVALUE, PH_CONTINUE: begin
          if (c == CharNl) begin
            n_res        = 2'd1;
            res0.kind    = KIND_ENTRY_END;
            phase_d      = PH_FIRST;
            name_cnt_d   = '0;
            value_cnt_d  = '0;
            held_valid_d = 1'b0;
            held_char_d  = 8'h00;
          end else if (!is_blank(c)) begin
            n_res   = {1'b0, value_emit};
            res0    = value_res;
            phase_d = PH_VALUE;
            if (value_ok) begin
              value_cnt_d  = value_cnt_q + ValueCw'(1);
              held_char_d  = c;
              held_valid_d = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          if (c == CharNl) begin
            if (held_valid_q && (held_char_q == CharBslash)) begin
              // A trailing backslash continues the value on the next line.
              n_res        = 2'd1;
              res0         = '{kind: KIND_VALUE_CHAR, ch: CharCr};
              held_valid_d = 1'b0;
              held_char_d  = 8'h00;
              phase_d      = PH_CONTINUE;
            end else begin
              if (held_valid_q) begin
                n_res = 2'd2;
                res0  = '{kind: KIND_VALUE_CHAR, ch: held_char_q};
                res1  = '{kind: KIND_ENTRY_END, ch: 8'h00};
              end else begin
                n_res = 2'd1;
                res0  = '{kind: KIND_ENTRY_END, ch: 8'h00};
              end
              phase_d      = PH_FIRST;
              name_cnt_d   = '0;
              value_cnt_d  = '0;
              held_valid_d = 1'b0;
              held_char_d  = 8'h00;
            end
          end else begin
            n_res = {1'b0, value_emit};
            res0  = value_res;
            if (value_ok) begin
              value_cnt_d  = value_cnt_q + ValueCw'(1);
              held_char_d  = c;
              held_valid_d = 1'b1;
            end
          end
        end
        default: begin
          // First column: every entry starts from cleared state.
          name_cnt_d   = '0;
          value_cnt_d  = '0;
          held_valid_d = 1'b0;
          held_char_d  = 8'h00;
          if (c == CharHash) begin
            phase_d = PH_COMMENT;
          end else if (c == CharNl) begin
            phase_d = PH_FIRST;
          end else if (is_blank(c)) begin
            phase_d = PH_FINDNAME;
          end else begin
            n_res   = 2'd1;
            res0    = name_res;
            phase_d = PH_NAME;
            if (name_ok) begin
              name_cnt_d = name_base + NameCw'(1);
            end
          end
        end
      endcase
    end
  end

  // Characters that cause no result leave the queue alone.
  assign push_o         = accept && (n_res != 2'd0);
  assign entry_o.two    = n_res[1];
  assign entry_o.first  = res0;
  assign entry_o.second = res1;

  // Parser state advances only on an accepted character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_FIRST;
      name_cnt_q   <= '0;
      value_cnt_q  <= '0;
      held_valid_q <= 1'b0;
      held_char_q  <= 8'h00;
    end else if (accept) begin
      phase_q      <= phase_d;
      name_cnt_q   <= name_cnt_d;
      value_cnt_q  <= value_cnt_d;
      held_valid_q <= held_valid_d;
      held_char_q  <= held_char_d;
    end
  end

endmodule

// ===== rtl/nvt_fifo.sv =====
// ----------------------------------------------------------------------------
// nvt_fifo
// Short queue of result entries between the parser and the output side.
// ----------------------------------------------------------------------------
module nvt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nvt_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output nvt_pkg::entry_t data_o,
  output logic            empty_o
);
  import nvt_pkg::*;
  `include "name_value_line_tokenizer_macros.svh"

  entry_t            mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `NVT_ASSERT_IMP(a_no_push_full, push_i, !full_o, "queue written while full")
  `NVT_ASSERT_IMP(a_no_pop_empty, pop_i, !empty_o, "queue read while empty")
  `NVT_ASSERT(a_cnt_range, cnt_q <= QCntW'(QueueDepth), "queue count out of range")

endmodule

// ===== rtl/nvt_back.sv =====
// ----------------------------------------------------------------------------
// nvt_back
// Takes queue entries and sends their results one per request through an
// output register, marking the final result of each character.
// ----------------------------------------------------------------------------
module nvt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  output logic            pop_o,
  input  nvt_pkg::entry_t entry_i,
  input  logic            empty_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output nvt_pkg::out_t   out_o
);
  import nvt_pkg::*;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;
  logic sec_pend_q, sec_pend_d;
  res_t sec_q, sec_d;
  logic load;

  assign load = !out_valid_q || out_ready_i;

  // Refill the output register from the pending second result or the queue.
  always_comb begin
    pop_o       = 1'b0;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    sec_pend_d  = sec_pend_q;
    sec_d       = sec_q;
    if (load) begin
      if (sec_pend_q) begin
        out_valid_d = 1'b1;
        out_d       = '{kind: sec_q.kind, out_char: sec_q.ch, last: 1'b1};
        sec_pend_d  = 1'b0;
      end else if (!empty_i) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        out_d       = '{kind: entry_i.first.kind, out_char: entry_i.first.ch,
                        last: !entry_i.two};
        sec_pend_d  = entry_i.two;
        sec_d       = entry_i.second;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_pend_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sec_pend_q  <= sec_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    sec_q <= sec_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/name_value_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// name_value_line_tokenizer
// Splits a character stream into name/value entries with overflow limits.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o/in_i) takes one character per
//   request, or an end-of-text mark. The output channel (out_valid_o/
//   out_ready_i/out_o) delivers zero, one or two results per character;
//   the final result of a character carries last.
//   A result is written into the queue at the edge that accepts its
//   character and then registered in the output register. Throughput: one
//   character per cycle while out_ready_i is high, bounded by the single
//   output register that sends one result per cycle, so a character that
//   causes two results (value end with a held character) loads it twice.
//   A two-entry queue separates the parser from the output register. When
//   the receiver stalls, results collect there and in_ready_o drops once the
//   queue is full; the parser state holds until characters flow again.
//   Reset clears the parser to the first column, empties the queue and sets
//   the limits to 255 and 2047. The user must write the limits over the APB
//   port only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module name_value_line_tokenizer #(
  parameter int unsigned MAX_NAME  = nvt_pkg::MaxNameDefault,
  parameter int unsigned MAX_VALUE = nvt_pkg::MaxValueDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  nvt_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output nvt_pkg::out_t out_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import nvt_pkg::*;

  logic [NameLimitW-1:0]  name_limit_q;
  logic [ValueLimitW-1:0] value_limit_q;
  logic                   cfg_wr, push, pop, full, empty;
  entry_t                 push_entry, pop_entry;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_limit_q  <= NameLimitRst;
      value_limit_q <= ValueLimitRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegNameLimit: begin
          name_limit_q <= pwdata[NameLimitW-1:0];
        end
        RegValueLimit: begin
          value_limit_q <= pwdata[ValueLimitW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      RegNameLimit: begin
        prdata = {{(32 - NameLimitW){1'b0}}, name_limit_q};
      end
      RegValueLimit: begin
        prdata = {{(32 - ValueLimitW){1'b0}}, value_limit_q};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  nvt_front #(
    .MAX_NAME  (MAX_NAME),
    .MAX_VALUE (MAX_VALUE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_i          (in_i),
    .name_limit_i  (name_limit_q),
    .value_limit_i (value_limit_q),
    .push_o        (push),
    .entry_o       (push_entry),
    .full_i        (full)
  );

  nvt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .empty_o (empty)
  );

  nvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (pop),
    .entry_i     (pop_entry),
    .empty_i     (empty),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
